FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// Package: transaction types, buffer entry layout, codes and control structs for the buffer cache.
package bbc_pkg;

  localparam logic [2:0] KIND_GET    = 3'd0;
  localparam logic [2:0] KIND_VALID  = 3'd1;
  localparam logic [2:0] KIND_REL    = 3'd2;
  localparam logic [2:0] KIND_PIN    = 3'd3;
  localparam logic [2:0] KIND_UNPIN  = 3'd4;

  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  localparam logic [7:0] CNT_MAX = 8'hff;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
    logic [31:0] time_now;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] granted_index;
    logic       needs_read;
    logic [7:0] use_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic [31:0] rel;
    logic        dv;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_inc;
    logic rd_en;
    logic rd_scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/bbc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, buffer scan, read-modify-write and result hand-off.
module bbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbc_pkg::sts_t sts,
  output bbc_pkg::cmd_t cmd
);

  bbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      bbc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = bbc_pkg::S_DISPATCH;
        end
      end
      bbc_pkg::S_DISPATCH: begin
        if (sts.is_get) begin
          state_nxt = bbc_pkg::S_SCAN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = bbc_pkg::S_FINISH;
        end
      end
      bbc_pkg::S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_scan  = 1'b1;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) begin
          state_nxt = bbc_pkg::S_DRAIN;
        end
      end
      bbc_pkg::S_DRAIN: begin
        state_nxt = bbc_pkg::S_FINISH;
      end
      bbc_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = bbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bbc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bbc_dpath.sv
`timescale 1ns / 1ps
// Datapath: buffer entry memory, scan trackers, update logic and result register.
module bbc_dpath #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bbc_pkg::in_t  in_data,
  input  bbc_pkg::cmd_t cmd,
  output bbc_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output bbc_pkg::out_t out_data
);

  localparam int IW = $clog2(NUM_BUFFERS);

  bbc_pkg::entry_t mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] ent_vld_r;

  bbc_pkg::in_t    in_q_r;
  bbc_pkg::entry_t rd_data_r;
  logic            rd_vld_r;
  logic            rd_live_r;
  logic [IW-1:0]   rd_addr_r;
  logic [IW-1:0]   scan_cnt_r;

  logic            hit_r;
  logic [IW-1:0]   hit_idx_r;
  bbc_pkg::entry_t hit_ent_r;
  logic            free_r;
  logic [IW-1:0]   pick_r;
  logic [31:0]     pick_time_r;

  bbc_pkg::out_t   out_data_r;
  logic            out_valid_r;

  logic [IW-1:0]   idx_a;
  logic [IW-1:0]   rd_addr;
  bbc_pkg::entry_t ent;
  logic            is_bad;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  bbc_pkg::entry_t wr_ent;
  bbc_pkg::out_t   res;

  assign idx_a   = IW'(in_q_r.buffer_index);
  assign rd_addr = cmd.rd_scan ? scan_cnt_r : idx_a;
  assign ent     = rd_vld_r ? rd_data_r : '0;
  assign is_bad  = (in_q_r.kind > bbc_pkg::KIND_UNPIN) ||
                   (32'(in_q_r.buffer_index) >= NUM_BUFFERS);

  assign sts.is_get    = (in_q_r.kind == bbc_pkg::KIND_GET);
  assign sts.scan_last = (scan_cnt_r == IW'(NUM_BUFFERS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_q_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= ent_vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (cmd.commit && wr_en) begin
      ent_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r  <= 1'b0;
      scan_cnt_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      rd_live_r <= cmd.rd_en && cmd.rd_scan;
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else begin
        if (cmd.scan_inc) begin
          scan_cnt_r <= scan_cnt_r + IW'(1);
        end
        if (rd_live_r) begin
          if (!hit_r && ent.dev == in_q_r.device_id && ent.blk == in_q_r.block_number) begin
            hit_r <= 1'b1;
          end
          if (ent.cnt == 8'd0 && (!free_r || ent.rel < pick_time_r)) begin
            free_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_live_r && !cmd.scan_clr) begin
      if (!hit_r && ent.dev == in_q_r.device_id && ent.blk == in_q_r.block_number) begin
        hit_idx_r <= rd_addr_r;
        hit_ent_r <= ent;
      end
      if (ent.cnt == 8'd0 && (!free_r || ent.rel < pick_time_r)) begin
        pick_r      <= rd_addr_r;
        pick_time_r <= ent.rel;
      end
    end
  end

  always_comb begin
    wr_en             = 1'b0;
    wr_addr           = idx_a;
    wr_ent            = ent;
    res.status        = bbc_pkg::ST_DONE;
    res.granted_index = in_q_r.buffer_index;
    res.needs_read    = !ent.dv;
    res.use_count     = ent.cnt;
    if (in_q_r.kind == bbc_pkg::KIND_GET) begin
      if (hit_r) begin
        wr_addr           = hit_idx_r;
        wr_ent            = hit_ent_r;
        res.granted_index = 5'(hit_idx_r);
        res.needs_read    = !hit_ent_r.dv;
        if (hit_ent_r.cnt == bbc_pkg::CNT_MAX) begin
          res.status    = bbc_pkg::ST_ERR;
          res.use_count = hit_ent_r.cnt;
        end else begin
          wr_en         = 1'b1;
          wr_ent.cnt    = hit_ent_r.cnt + 8'd1;
          res.status    = bbc_pkg::ST_HIT;
          res.use_count = hit_ent_r.cnt + 8'd1;
        end
      end else if (free_r) begin
        wr_en             = 1'b1;
        wr_addr           = pick_r;
        wr_ent.dev        = in_q_r.device_id;
        wr_ent.blk        = in_q_r.block_number;
        wr_ent.cnt        = 8'd1;
        wr_ent.rel        = pick_time_r;
        wr_ent.dv         = 1'b0;
        res.status        = bbc_pkg::ST_MISS;
        res.granted_index = 5'(pick_r);
        res.needs_read    = 1'b1;
        res.use_count     = 8'd1;
      end else begin
        res.status        = bbc_pkg::ST_FULL;
        res.granted_index = 5'd0;
        res.needs_read    = 1'b0;
        res.use_count     = 8'd0;
      end
    end else if (is_bad) begin
      res.status     = bbc_pkg::ST_ERR;
      res.needs_read = 1'b0;
      res.use_count  = 8'd0;
    end else begin
      case (in_q_r.kind)
        bbc_pkg::KIND_VALID: begin
          wr_en          = 1'b1;
          wr_ent.dv      = 1'b1;
          res.needs_read = 1'b0;
        end
        bbc_pkg::KIND_REL: begin
          if (ent.cnt == 8'd0) begin
            res.status = bbc_pkg::ST_ERR;
          end else begin
            wr_en         = 1'b1;
            wr_ent.cnt    = ent.cnt - 8'd1;
            res.use_count = ent.cnt - 8'd1;
            if (ent.cnt == 8'd1) begin
              wr_ent.rel = in_q_r.time_now;
            end
          end
        end
        bbc_pkg::KIND_PIN: begin
          if (ent.cnt == bbc_pkg::CNT_MAX) begin
            res.status = bbc_pkg::ST_ERR;
          end else begin
            wr_en         = 1'b1;
            wr_ent.cnt    = ent.cnt + 8'd1;
            res.use_count = ent.cnt + 8'd1;
          end
        end
        bbc_pkg::KIND_UNPIN: begin
          if (ent.cnt == 8'd0) begin
            res.status = bbc_pkg::ST_ERR;
          end else begin
            wr_en         = 1'b1;
            wr_ent.cnt    = ent.cnt - 8'd1;
            res.use_count = ent.cnt - 8'd1;
          end
        end
        default: begin
          res.status = bbc_pkg::ST_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: sv/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// Top level: reference-counted buffer cache tag store with least-recently-released replacement.
//
// One transaction in gives one result out. A get request scans every buffer entry, one per
// cycle through the single read port of the entry memory, for a tag match and for the unused
// buffer with the oldest release time (lowest index on ties); a drain state follows the scan.
// Mark valid, release, pin and unpin do one read-modify-write of the addressed entry. The
// result is registered in the output register once that register is free, and only then
// is the next transaction taken. One transaction is worked on at a time; the next may be
// accepted while the previous result waits in the output register.
// All entries read as zero after reset through per-entry valid bits, with no clearing pass.
module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bbc_pkg::out_t out_data
);

  bbc_pkg::cmd_t cmd;
  bbc_pkg::sts_t sts;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbc_dpath #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
